// ===== rtl/core/cartesian_to_polar_assert.svh =====
// Assertion macros used by the output stage of the rectangular-to-polar converter.
`ifndef CARTESIAN_TO_POLAR_ASSERT_SVH
`define CARTESIAN_TO_POLAR_ASSERT_SVH

// Checks a consequence in the same cycle as its condition.
`define C2P_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c2p assertion failed");

// Checks a consequence in the cycle after its condition.
`define C2P_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c2p assertion failed");

`endif

// ===== rtl/core/c2p_pkg.sv =====
// Shared types, constants and elaboration-time functions for the converter.
package c2p_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAG_W             = 16;
  localparam int ANG_W             = 17;
  localparam int XY_W              = 64;
  localparam int Z_W               = 36;
  localparam int XY_SCALE_POS      = 60;
  localparam int ANG_SHIFT         = 19;
  localparam int ANGLE_MAX         = 38603;
  localparam int MAG_MAX           = 65535;

  localparam logic signed [Z_W-1:0] PI_Q32         = 36'sd13493037704;
  localparam logic signed [Z_W-1:0] HALF_PI_Q32    = 36'sd6746518852;
  localparam logic signed [Z_W-1:0] QUARTER_PI_Q32 = 36'sd3373259426;
  localparam logic signed [Z_W-1:0] ROUND_HALF     = 36'sd262144;

  localparam logic signed [ANG_W-1:0] ANG_HALF_PI =
    ANG_W'((HALF_PI_Q32 + ROUND_HALF) >>> ANG_SHIFT);
  localparam logic signed [ANG_W-1:0] ANG_NEG_HALF_PI =
    ANG_W'((ROUND_HALF - HALF_PI_Q32) >>> ANG_SHIFT);

  typedef logic signed [XY_W-1:0] c2p_xy_t;
  typedef logic signed [Z_W-1:0]  c2p_z_t;

  typedef struct packed {
    logic zero_vec;
    logic x_zero;
    logic x_neg;
    logic y_pos;
  } c2p_flags_t;

  // Shift-and-subtract quotient, used only to build constant tables.
  function automatic logic [63:0] udiv_const(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Rotation angle atan(2^-i) in Q32 radians, summed from its power series.
  function automatic logic signed [Z_W-1:0] atan_pow2(input int i);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] term;
    logic signed [63:0] sum;
    if (i == 0) begin
      return QUARTER_PI_Q32;
    end
    if (i > 32) begin
      return '0;
    end
    t   = 64'd1 << (32 - i);
    t2  = (t * t) >> 32;
    p   = t;
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      if (p != '0) begin
        term = udiv_const(p, 64'(2 * k + 1));
        if (k[0]) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
        p = (p * t2) >> 32;
      end
    end
    return Z_W'(sum);
  endfunction

endpackage

// ===== rtl/core/c2p_if.sv =====
// Handshake channels for the coordinate input and the polar result.
interface c2p_in_if
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;

  modport source (output valid, x_coord, y_coord, input ready);
  modport sink (input valid, x_coord, y_coord, output ready);
endinterface

interface c2p_out_if
  import c2p_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic        [MAG_W-1:0] magnitude;
  logic signed [ANG_W-1:0] angle;

  modport source (output valid, magnitude, angle, input ready);
  modport sink (input valid, magnitude, angle, output ready);
endinterface

// ===== rtl/core/cartesian_to_polar.sv =====
// Top level of the pipelined rectangular-to-polar converter.
// Channels: in_ch carries a signed vector (x_coord, y_coord) of COORD_WIDTH bits;
// out_ch returns its rounded length (magnitude) and its angle in radians times
// 8192 (angle), from minus half pi up to just below three halves pi.
// Both channels move one beat when valid and ready are high at a clock edge.
// N = max(CORDIC_STAGES, COORD_WIDTH). Two front stages fold the quadrant and
// form x*x + y*y; of the N step stages, the first CORDIC_STAGES each do one CORDIC
// rotation and the first COORD_WIDTH each do one square-root digit, and one stage
// rounds and registers the result. Throughput is one beat per cycle unless
// out_ch holds ready low; the N step stages set the pipeline depth.
// Reset clears every stage's valid bit, so the pipeline starts empty.
// When a result waits at out_ch and ready is low, the whole pipeline holds and
// in_ch.ready falls in the same cycle; nothing is dropped or repeated.
module cartesian_to_polar
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  c2p_in_if.sink     in_ch,
  c2p_out_if.source  out_ch
);

  localparam int N    = (CORDIC_STAGES > COORD_WIDTH) ? CORDIC_STAGES : COORD_WIDTH;
  localparam int SQ_W = 2 * COORD_WIDTH;

  logic                          adv;
  logic                          out_valid;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;

  logic            vld  [0:N];
  c2p_flags_t      flg  [0:N];
  c2p_xy_t         xs   [0:N];
  c2p_xy_t         ys   [0:N];
  c2p_z_t          zs   [0:N];
  logic [SQ_W-1:0] rems [0:N];
  logic [SQ_W-1:0] ress [0:N];

  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign x_in        = in_ch.x_coord;
  assign y_in        = in_ch.y_coord;
  assign zs[0]       = '0;
  assign ress[0]     = '0;

  c2p_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv_i   (adv),
    .valid_i (in_ch.valid),
    .x_i     (x_in),
    .y_i     (y_in),
    .valid_o (vld[0]),
    .flags_o (flg[0]),
    .x_o     (xs[0]),
    .y_o     (ys[0]),
    .n_o     (rems[0])
  );

  generate
    for (genvar g = 0; g < N; g++) begin : g_step
      c2p_stage #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STAGES(CORDIC_STAGES),
        .IDX          (g)
      ) u_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv_i   (adv),
        .valid_i (vld[g]),
        .flags_i (flg[g]),
        .x_i     (xs[g]),
        .y_i     (ys[g]),
        .z_i     (zs[g]),
        .rem_i   (rems[g]),
        .res_i   (ress[g]),
        .valid_o (vld[g+1]),
        .flags_o (flg[g+1]),
        .x_o     (xs[g+1]),
        .y_o     (ys[g+1]),
        .z_o     (zs[g+1]),
        .rem_o   (rems[g+1]),
        .res_o   (ress[g+1])
      );
    end
  endgenerate

  c2p_post #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv_i       (adv),
    .valid_i     (vld[N]),
    .flags_i     (flg[N]),
    .z_i         (zs[N]),
    .rem_i       (rems[N]),
    .res_i       (ress[N]),
    .valid_o     (out_valid),
    .magnitude_o (out_ch.magnitude),
    .angle_o     (out_ch.angle)
  );

  assign out_ch.valid = out_valid;

endmodule

// ===== rtl/core/c2p_prep.sv =====
// Front stages: quadrant folding, CORDIC seeding and the sum of squares.
module c2p_prep
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  output logic                          valid_o,
  output c2p_flags_t                    flags_o,
  output c2p_xy_t                       x_o,
  output c2p_xy_t                       y_o,
  output logic [2*COORD_WIDTH-1:0]      n_o
);

  localparam int SQ_W = 2 * COORD_WIDTH;

  logic                   a_valid_r;
  c2p_flags_t             a_flags_r, a_flags_nxt;
  c2p_xy_t                a_x_r, a_x_nxt;
  c2p_xy_t                a_y_r, a_y_nxt;
  logic [SQ_W-1:0]        a_sqx_r, a_sqx_nxt;
  logic [SQ_W-1:0]        a_sqy_r, a_sqy_nxt;

  logic                   b_valid_r;
  c2p_flags_t             b_flags_r;
  c2p_xy_t                b_x_r;
  c2p_xy_t                b_y_r;
  logic [SQ_W-1:0]        b_n_r;

  c2p_xy_t                x_ext;
  c2p_xy_t                y_ext;
  logic [COORD_WIDTH-1:0] ax;
  logic [COORD_WIDTH-1:0] ay;

  always_comb begin
    x_ext = {{(XY_W-COORD_WIDTH){x_i[COORD_WIDTH-1]}}, x_i};
    y_ext = {{(XY_W-COORD_WIDTH){y_i[COORD_WIDTH-1]}}, y_i};
    ax    = x_i[COORD_WIDTH-1] ? COORD_WIDTH'(-x_i) : COORD_WIDTH'(x_i);
    ay    = y_i[COORD_WIDTH-1] ? COORD_WIDTH'(-y_i) : COORD_WIDTH'(y_i);

    a_flags_nxt.zero_vec = (x_i == '0) && (y_i == '0);
    a_flags_nxt.x_zero   = (x_i == '0);
    a_flags_nxt.x_neg    = x_i[COORD_WIDTH-1];
    a_flags_nxt.y_pos    = !y_i[COORD_WIDTH-1] && (y_i != '0);

    // Vectors in the left half plane are turned by pi before the CORDIC.
    if (x_i[COORD_WIDTH-1]) begin
      a_x_nxt = (-x_ext) <<< (XY_SCALE_POS - COORD_WIDTH);
      a_y_nxt = (-y_ext) <<< (XY_SCALE_POS - COORD_WIDTH);
    end else begin
      a_x_nxt = x_ext <<< (XY_SCALE_POS - COORD_WIDTH);
      a_y_nxt = y_ext <<< (XY_SCALE_POS - COORD_WIDTH);
    end

    a_sqx_nxt = ax * ax;
    a_sqy_nxt = ay * ay;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (adv_i) begin
      a_valid_r <= valid_i;
      b_valid_r <= a_valid_r;
    end
    if (adv_i) begin
      a_flags_r <= a_flags_nxt;
      a_x_r     <= a_x_nxt;
      a_y_r     <= a_y_nxt;
      a_sqx_r   <= a_sqx_nxt;
      a_sqy_r   <= a_sqy_nxt;
      b_flags_r <= a_flags_r;
      b_x_r     <= a_x_r;
      b_y_r     <= a_y_r;
      b_n_r     <= a_sqx_r + a_sqy_r;
    end
  end

  assign valid_o = b_valid_r;
  assign flags_o = b_flags_r;
  assign x_o     = b_x_r;
  assign y_o     = b_y_r;
  assign n_o     = b_n_r;

endmodule

// ===== rtl/core/c2p_stage.sv =====
// One pipeline stage: a CORDIC vectoring step if IDX < CORDIC_STAGES and one square-root digit if IDX < COORD_WIDTH.
module c2p_stage
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int IDX           = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  c2p_flags_t               flags_i,
  input  c2p_xy_t                  x_i,
  input  c2p_xy_t                  y_i,
  input  c2p_z_t                   z_i,
  input  logic [2*COORD_WIDTH-1:0] rem_i,
  input  logic [2*COORD_WIDTH-1:0] res_i,
  output logic                     valid_o,
  output c2p_flags_t               flags_o,
  output c2p_xy_t                  x_o,
  output c2p_xy_t                  y_o,
  output c2p_z_t                   z_o,
  output logic [2*COORD_WIDTH-1:0] rem_o,
  output logic [2*COORD_WIDTH-1:0] res_o
);

  localparam int SQ_W = 2 * COORD_WIDTH;

  logic            valid_r;
  c2p_flags_t      flags_r;
  c2p_xy_t         x_r, x_nxt;
  c2p_xy_t         y_r, y_nxt;
  c2p_z_t          z_r, z_nxt;
  logic [SQ_W-1:0] rem_r, rem_nxt;
  logic [SQ_W-1:0] res_r, res_nxt;

  generate
    if (IDX < CORDIC_STAGES) begin : g_rot
      localparam c2p_z_t ATAN_K = atan_pow2(IDX);
      c2p_xy_t dx;
      c2p_xy_t dy;
      always_comb begin
        dx = y_i >>> IDX;
        dy = x_i >>> IDX;
        if (!y_i[XY_W-1]) begin
          x_nxt = x_i + dx;
          y_nxt = y_i - dy;
          z_nxt = z_i + ATAN_K;
        end else begin
          x_nxt = x_i - dx;
          y_nxt = y_i + dy;
          z_nxt = z_i - ATAN_K;
        end
      end
    end else begin : g_rot_pass
      always_comb begin
        x_nxt = x_i;
        y_nxt = y_i;
        z_nxt = z_i;
      end
    end

    if (IDX < COORD_WIDTH) begin : g_root
      localparam int BIT_POS = 2 * (COORD_WIDTH - 1 - IDX);
      localparam logic [SQ_W:0] BIT_K = (SQ_W+1)'(1) << BIT_POS;
      logic [SQ_W:0] trial;
      always_comb begin
        trial = {1'b0, res_i} + BIT_K;
        if ({1'b0, rem_i} >= trial) begin
          rem_nxt = rem_i - trial[SQ_W-1:0];
          res_nxt = (res_i >> 1) + BIT_K[SQ_W-1:0];
        end else begin
          rem_nxt = rem_i;
          res_nxt = res_i >> 1;
        end
      end
    end else begin : g_root_pass
      always_comb begin
        rem_nxt = rem_i;
        res_nxt = res_i;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv_i) begin
      valid_r <= valid_i;
    end
    if (adv_i) begin
      flags_r <= flags_i;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      rem_r   <= rem_nxt;
      res_r   <= res_nxt;
    end
  end

  assign valid_o = valid_r;
  assign flags_o = flags_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign rem_o   = rem_r;
  assign res_o   = res_r;

endmodule

// ===== rtl/core/c2p_post.sv =====
// Output stage: magnitude rounding and saturation, angle selection and scaling.
`include "cartesian_to_polar_assert.svh"
module c2p_post
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  c2p_flags_t               flags_i,
  input  c2p_z_t                   z_i,
  input  logic [2*COORD_WIDTH-1:0] rem_i,
  input  logic [2*COORD_WIDTH-1:0] res_i,
  output logic                     valid_o,
  output logic [MAG_W-1:0]         magnitude_o,
  output logic signed [ANG_W-1:0]  angle_o
);

  logic                    out_valid_r;
  logic [MAG_W-1:0]        magnitude_r, magnitude_nxt;
  logic signed [ANG_W-1:0] angle_r, angle_nxt;

  logic [COORD_WIDTH:0]    mag_wide;
  c2p_z_t                  ang_base;
  c2p_z_t                  ang_sum;
  c2p_z_t                  ang_scaled;

  always_comb begin
    // Round up when the remainder left by the root exceeds the root itself.
    mag_wide = {1'b0, res_i[COORD_WIDTH-1:0]} + (COORD_WIDTH+1)'(rem_i > res_i);
    if (mag_wide > MAG_MAX) begin
      magnitude_nxt = MAG_W'(MAG_MAX);
    end else begin
      magnitude_nxt = MAG_W'(mag_wide);
    end

    ang_base   = flags_i.x_neg ? (PI_Q32 + ROUND_HALF) : ROUND_HALF;
    ang_sum    = z_i + ang_base;
    ang_scaled = ang_sum >>> ANG_SHIFT;

    if (flags_i.zero_vec) begin
      angle_nxt = '0;
    end else if (flags_i.x_zero) begin
      angle_nxt = flags_i.y_pos ? ANG_HALF_PI : ANG_NEG_HALF_PI;
    end else if (ang_scaled > ANGLE_MAX) begin
      angle_nxt = ANG_W'(ANGLE_MAX);
    end else begin
      angle_nxt = ang_scaled[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_i) begin
      out_valid_r <= valid_i;
    end
    if (adv_i) begin
      magnitude_r <= magnitude_nxt;
      angle_r     <= angle_nxt;
    end
  end

  assign valid_o     = out_valid_r;
  assign magnitude_o = magnitude_r;
  assign angle_o     = angle_r;

  // Only the zero vector has zero length, and its angle is zero.
  `C2P_ASSERT_NOW(a_zero_len_zero_angle, out_valid_r && magnitude_r == '0, angle_r == '0)
  `C2P_ASSERT_NEXT(a_up_axis, valid_i && adv_i && flags_i.x_zero && !flags_i.zero_vec && flags_i.y_pos, out_valid_r && angle_r == ANG_HALF_PI)
  `C2P_ASSERT_NEXT(a_left_half, valid_i && adv_i && flags_i.x_neg, out_valid_r && angle_r > 0 && angle_r <= ANGLE_MAX)

endmodule
